// ===== hw/rtl/kwq_pkg.sv =====
package kwq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_BITS    = 16;
   localparam int USER_BITS   = 16;

   // Channel field widths
   localparam int MODE_W   = 2;
   localparam int KEY_W    = 16;
   localparam int USER_W   = 16;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 5;

   // Derived storage widths
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Keep only the significant key and user bits
   localparam logic [KEY_W-1:0]  KEY_MASK  = KEY_W'((64'd1 << KEY_BITS) - 64'd1);
   localparam logic [USER_W-1:0] USER_MASK = USER_W'((64'd1 << USER_BITS) - 64'd1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ   = 2'd0,
      MODE_DEQ   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DEQUEUED  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_COMMIT = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request and search the cells
      logic commit;  // apply the update and load the result register
   } dp_cmd_type;

endpackage

// ===== hw/rtl/kwq_req_if.sv =====
interface kwq_req_if;
   logic                        valid;
   logic                        ready;
   logic [kwq_pkg::MODE_W-1:0]  mode;
   logic [kwq_pkg::KEY_W-1:0]   item_key;
   logic [kwq_pkg::USER_W-1:0]  user_in;

   modport source (output valid, output mode, output item_key, output user_in, input ready);
   modport sink   (input valid, input mode, input item_key, input user_in, output ready);
endinterface

// ===== hw/rtl/kwq_rsp_if.sv =====
interface kwq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kwq_pkg::STATUS_W-1:0]  status;
   logic [kwq_pkg::USER_W-1:0]    user_out;
   logic [kwq_pkg::FILL_W-1:0]    fill_count;

   modport source (output valid, output status, output user_out, output fill_count,
                   input ready);
   modport sink   (input valid, input status, input user_out, input fill_count,
                   output ready);
endinterface

// ===== hw/rtl/kwq_datapath.sv =====
module kwq_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  kwq_pkg::dp_cmd_type            cmd,
   input  logic [kwq_pkg::MODE_W-1:0]     req_mode,
   input  logic [kwq_pkg::KEY_W-1:0]      req_item_key,
   input  logic [kwq_pkg::USER_W-1:0]     req_user_in,
   output logic [kwq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [kwq_pkg::USER_W-1:0]     rsp_user_out,
   output logic [kwq_pkg::FILL_W-1:0]     rsp_fill_count
);

   localparam int DEPTH = kwq_pkg::QUEUE_DEPTH;
   localparam int CNT_W = kwq_pkg::CNT_W;
   localparam int IDX_W = kwq_pkg::IDX_W;

   // Cell row, slot 0 is the head
   logic [kwq_pkg::KEY_W-1:0]  key_cell_ff  [DEPTH];
   logic [kwq_pkg::USER_W-1:0] user_cell_ff [DEPTH];
   logic [kwq_pkg::KEY_W-1:0]  key_next     [DEPTH];
   logic [kwq_pkg::USER_W-1:0] user_next    [DEPTH];
   logic [CNT_W-1:0]           count_ff, count_in;

   // Captured request and search result
   logic [kwq_pkg::MODE_W-1:0] mode_ff;
   logic [kwq_pkg::KEY_W-1:0]  key_ff, key_masked;
   logic [kwq_pkg::USER_W-1:0] user_ff;
   logic [DEPTH-1:0]           match_vec, first_vec, first_ff, shift_vec;
   logic                       hit_ff;

   // Result register
   kwq_pkg::status_type        status_ff, status_in;
   logic [kwq_pkg::USER_W-1:0] user_out_ff, user_out_in;
   logic [kwq_pkg::FILL_W-1:0] fill_ff;

   logic full;
   logic enq_we;
   logic deq_we;
   logic [kwq_pkg::USER_W-1:0] found_user;

   assign key_masked = req_item_key & kwq_pkg::KEY_MASK;

   // Compare every occupied cell, keep the oldest match
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = (CNT_W'(i) < count_ff) && (key_cell_ff[i] == key_masked);
      end
      first_vec = match_vec & (~match_vec + DEPTH'(1));
   end

   // Capture request at transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         key_ff   <= key_masked;
         user_ff  <= req_user_in & kwq_pkg::USER_MASK;
         first_ff <= first_vec;
         hit_ff   <= |match_vec;
      end
   end

   // Source for compaction: each cell takes its younger neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_next
      if (g < DEPTH - 1) begin : g_mid
         assign key_next[g]  = key_cell_ff[g+1];
         assign user_next[g] = user_cell_ff[g+1];
      end else begin : g_tail
         assign key_next[g]  = key_cell_ff[g];
         assign user_next[g] = user_cell_ff[g];
      end
   end

   // Select the removed user and mark cells at or past it
   always_comb begin
      found_user = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_user = found_user | (user_cell_ff[i] & {kwq_pkg::USER_W{first_ff[i]}});
      end
      shift_vec[0] = first_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         shift_vec[i] = shift_vec[i-1] | first_ff[i];
      end
   end

   // Decide the update and the result
   always_comb begin
      full        = (count_ff == CNT_W'(DEPTH));
      count_in    = count_ff;
      status_in   = kwq_pkg::ST_NOT_FOUND;
      user_out_in = '0;
      enq_we      = 1'b0;
      deq_we      = 1'b0;
      case (mode_ff)
         kwq_pkg::MODE_ENQ: begin
            if (full) begin
               status_in = kwq_pkg::ST_FULL;
            end else begin
               status_in = kwq_pkg::ST_ENQUEUED;
               count_in  = count_ff + CNT_W'(1);
               enq_we    = cmd.commit;
            end
         end
         kwq_pkg::MODE_DEQ: begin
            if (hit_ff) begin
               status_in   = kwq_pkg::ST_DEQUEUED;
               user_out_in = found_user;
               count_in    = count_ff - CNT_W'(1);
               deq_we      = cmd.commit;
            end
         end
         kwq_pkg::MODE_CLEAR: begin
            status_in = kwq_pkg::ST_CLEARED;
            count_in  = '0;
         end
         default: begin
            status_in = kwq_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   // Append at the tail or close the gap
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (enq_we && (count_ff[IDX_W-1:0] == IDX_W'(i))) begin
            key_cell_ff[i]  <= key_ff;
            user_cell_ff[i] <= user_ff;
         end else if (deq_we && shift_vec[i]) begin
            key_cell_ff[i]  <= key_next[i];
            user_cell_ff[i] <= user_next[i];
         end
      end
   end

   // Fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status_in;
         user_out_ff <= user_out_in;
         fill_ff     <= kwq_pkg::FILL_W'(count_in);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_user_out   = user_out_ff;
   assign rsp_fill_count = fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond queue depth");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_ff))
      else $error("more than one oldest match selected");

   a_deq_shrinks: assert property (@(posedge clock) disable iff (reset)
      deq_we |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("dequeue did not remove exactly one entry");

endmodule

// ===== hw/rtl/kwq_ctrl.sv =====
module kwq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kwq_pkg::dp_cmd_type  cmd
);

   kwq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwq_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         kwq_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kwq_pkg::FSM_COMMIT;
            end
         end
         kwq_pkg::FSM_COMMIT: begin
            // hold until the result register is free or drains now
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = kwq_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = kwq_pkg::FSM_IDLE;
         end
      endcase
   end

   // Result valid: set on commit, drop on transfer
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == kwq_pkg::FSM_COMMIT)
      else $error("accepted request not followed by commit state");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kwq_pkg::FSM_COMMIT && rsp_valid_ff && !rsp_ready) |-> !cmd.commit)
      else $error("pending result overwritten");

endmodule

// ===== hw/rtl/keyed_wait_queue.sv =====
// The request and its search result are captured at request transfer; the result and its valid load at commit.
// The controller takes a request only while idle, so each request is committed before the
// next one is taken. A new request is taken while a result waits.
// A commit stalls only while an earlier result is still held at the output.
// Reset clears the fill count, the controller state and the result valid; the
// stored pairs keep their contents and are reached only below the fill count.
module keyed_wait_queue (
   input logic       clock,
   input logic       reset,
   kwq_req_if.sink   req_bus,
   kwq_rsp_if.source rsp_bus
);

   kwq_pkg::dp_cmd_type cmd;

   kwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   kwq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_bus.mode),
      .req_item_key   (req_bus.item_key),
      .req_user_in    (req_bus.user_in),
      .rsp_status     (rsp_bus.status),
      .rsp_user_out   (rsp_bus.user_out),
      .rsp_fill_count (rsp_bus.fill_count)
   );

endmodule

// ===== test/kwq_checker.sv =====
`timescale 1ns / 100ps

module kwq_checker (
   input  logic clock,
   input  logic reset,
   kwq_req_if   req_bus,
   kwq_rsp_if   rsp_bus,
   output int   error_count,
   output int   owed_count
);

   typedef struct packed {
      kwq_pkg::status_type                status;
      logic [kwq_pkg::USER_W-1:0]         user_out;
      logic [kwq_pkg::FILL_W-1:0]         fill_count;
   } reply_type;

   // Shadow of the waiting line, slot 0 is the oldest entry
   logic [kwq_pkg::KEY_W-1:0]  line_keys  [kwq_pkg::QUEUE_DEPTH];
   logic [kwq_pkg::USER_W-1:0] line_users [kwq_pkg::QUEUE_DEPTH];
   int                         line_count;
   reply_type                  owed_replies [$];

   initial begin
      error_count = 0;
      owed_count  = 0;
      line_count  = 0;
   end

   // Apply one request to the shadow line and return the reply it earns
   function automatic reply_type serve_request(logic [kwq_pkg::MODE_W-1:0] mode,
                                               logic [kwq_pkg::KEY_W-1:0]  key_raw,
                                               logic [kwq_pkg::USER_W-1:0] user_raw);
      logic [kwq_pkg::KEY_W-1:0]  key;
      logic [kwq_pkg::USER_W-1:0] user;
      reply_type                  reply;
      int                         hit_pos;
      key            = key_raw & kwq_pkg::KEY_MASK;
      user           = user_raw & kwq_pkg::USER_MASK;
      reply.status   = kwq_pkg::ST_NOT_FOUND;
      reply.user_out = '0;
      hit_pos        = -1;
      case (mode)
         kwq_pkg::MODE_ENQ: begin
            if (line_count >= kwq_pkg::QUEUE_DEPTH) begin
               reply.status = kwq_pkg::ST_FULL;
            end else begin
               line_keys[line_count]  = key;
               line_users[line_count] = user;
               line_count++;
               reply.status = kwq_pkg::ST_ENQUEUED;
            end
         end
         kwq_pkg::MODE_DEQ: begin
            // find the oldest match, then close the gap behind it
            for (int i = 0; i < line_count; i++) begin
               if (hit_pos < 0 && line_keys[i] == key) hit_pos = i;
            end
            if (hit_pos >= 0) begin
               reply.user_out = line_users[hit_pos];
               for (int i = hit_pos; i + 1 < line_count; i++) begin
                  line_keys[i]  = line_keys[i + 1];
                  line_users[i] = line_users[i + 1];
               end
               line_count--;
               reply.status = kwq_pkg::ST_DEQUEUED;
            end
         end
         kwq_pkg::MODE_CLEAR: begin
            line_count   = 0;
            reply.status = kwq_pkg::ST_CLEARED;
         end
         default: ;
      endcase
      reply.fill_count = kwq_pkg::FILL_W'(line_count);
      return reply;
   endfunction

   task automatic report_mismatch(string field, int want, int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compare result transfers first: a request taken at this edge cannot answer yet
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         line_count = 0;
         owed_replies.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_replies.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, %s %0d user %0d fill %0d",
                        $time, "actual status", rsp_bus.status, rsp_bus.user_out,
                        rsp_bus.fill_count);
            end else begin
               want = owed_replies.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", want.status, rsp_bus.status);
               if (rsp_bus.user_out !== want.user_out)
                  report_mismatch("user_out", want.user_out, rsp_bus.user_out);
               if (rsp_bus.fill_count !== want.fill_count)
                  report_mismatch("fill_count", want.fill_count, rsp_bus.fill_count);
            end
         end
         if (req_bus.valid && req_bus.ready)
            owed_replies.push_back(serve_request(req_bus.mode, req_bus.item_key,
                                                 req_bus.user_in));
      end
      owed_count = owed_replies.size();
   end

endmodule

// ===== test/keyed_wait_queue_tb.sv =====
`timescale 1ns / 100ps

module keyed_wait_queue_tb;

   localparam logic [kwq_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int                         CYCLE_LIMIT = 200000;
   localparam int                         SEGMENTS    = 37;
   localparam int                         SEG_ITEMS   = 50;

   logic clock;
   logic reset;
   bit   calm;
   int   cycle_count;
   int   error_count;
   int   owed_count;

   kwq_req_if req_bus ();
   kwq_rsp_if rsp_bus ();

   keyed_wait_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   kwq_checker audit (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .error_count (error_count),
      .owed_count  (owed_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Stall the result side at random, except in calm stretches
   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 13);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request, with an occasional gap before it, and hold until transfer
   task automatic send_item(logic [kwq_pkg::MODE_W-1:0] mode,
                            logic [kwq_pkg::KEY_W-1:0] key,
                            logic [kwq_pkg::USER_W-1:0] user);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= mode;
      req_bus.item_key <= key;
      req_bus.user_in  <= user;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold off new requests until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
   endtask

   // Mostly a small set of keys so that searches hit, sometimes any key
   function automatic logic [kwq_pkg::KEY_W-1:0] pick_key();
      logic [kwq_pkg::KEY_W-1:0] common_keys [6];
      common_keys = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5A5A, 16'h00FF};
      if ($urandom_range(0, 99) < 70) return common_keys[$urandom_range(0, 5)];
      return kwq_pkg::KEY_W'($urandom);
   endfunction

   initial begin
      int bias;
      int roll;
      cycle_count      = 0;
      calm             = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.mode     = kwq_pkg::MODE_ENQ;
      req_bus.item_key = '0;
      req_bus.user_in  = '0;
      rsp_bus.ready    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty line: search misses, clear still answers, spare mode is a miss
      send_item(kwq_pkg::MODE_DEQ, 16'h0000, 16'h0000);
      send_item(kwq_pkg::MODE_CLEAR, 16'h0000, 16'h0000);
      send_item(MODE_SPARE, 16'hFFFF, 16'hFFFF);

      // Fill to the brim, with a repeated key near the head
      send_item(kwq_pkg::MODE_ENQ, 16'h0000, 16'hFFFF);
      send_item(kwq_pkg::MODE_ENQ, 16'hFFFF, 16'h0000);
      send_item(kwq_pkg::MODE_ENQ, 16'h1234, 16'h0001);
      send_item(kwq_pkg::MODE_ENQ, 16'h1234, 16'h0002);
      for (int i = 4; i < kwq_pkg::QUEUE_DEPTH; i++)
         send_item(kwq_pkg::MODE_ENQ, kwq_pkg::KEY_W'(16'h0100 + i),
                   kwq_pkg::USER_W'(16'hA000 + i));
      send_item(kwq_pkg::MODE_ENQ, 16'h4321, 16'h5555);
      send_item(MODE_SPARE, 16'hFFFF, 16'h0000);

      // Oldest of duplicates, a middle entry, a miss, the head, then clear
      send_item(kwq_pkg::MODE_DEQ, 16'h1234, 16'h0000);
      send_item(kwq_pkg::MODE_DEQ, 16'hFFFF, 16'h0000);
      send_item(kwq_pkg::MODE_DEQ, 16'h7777, 16'h0000);
      send_item(kwq_pkg::MODE_DEQ, 16'h0000, 16'h0000);
      send_item(kwq_pkg::MODE_CLEAR, 16'h0000, 16'h0000);
      drain_results();

      // Random traffic in segments that lean toward filling or emptying
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         bias = $urandom_range(20, 85);
         calm = (seg >= 12 && seg < 18);
         if (seg == 20) drain_results();
         for (int n = 0; n < SEG_ITEMS; n++) begin
            roll = $urandom_range(0, 199);
            if (roll < 3)
               send_item(kwq_pkg::MODE_CLEAR, kwq_pkg::KEY_W'($urandom),
                         kwq_pkg::USER_W'($urandom));
            else if (roll < 7)
               send_item(MODE_SPARE, kwq_pkg::KEY_W'($urandom), kwq_pkg::USER_W'($urandom));
            else if ($urandom_range(0, 99) < bias)
               send_item(kwq_pkg::MODE_ENQ, pick_key(), kwq_pkg::USER_W'($urandom));
            else
               send_item(kwq_pkg::MODE_DEQ, pick_key(), kwq_pkg::USER_W'($urandom));
         end
      end
      calm = 1'b0;

      // Wait out the tail, then give the verdict
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
